[rtl/core/lcs_pkg.sv]
package lcs_pkg;

    // lookahead window depth, the longest comment starter that can match
    localparam int MAX_STARTER = 4;
    localparam int CNT_W       = $clog2(MAX_STARTER + 1);
    localparam int IDX_W       = (MAX_STARTER > 1) ? $clog2(MAX_STARTER) : 1;
    localparam int MAX_RESULTS = MAX_STARTER + 1;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    // character codes
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_BSLASH = 8'd92;

    // configuration register indexes
    localparam int         CFG_IDX_W          = 1;
    localparam logic [0:0] REG_STARTER_LENGTH = 1'd0;
    localparam logic [0:0] REG_STARTER_BYTES  = 1'd1;

    localparam logic [2:0]  RST_STARTER_LENGTH = 3'd2;
    localparam logic [31:0] RST_STARTER_BYTES  = 32'd12079;

    typedef struct packed {
        logic       outside;
        logic [7:0] data;
    } t_entry;

    typedef t_entry [MAX_STARTER-1:0] t_window;

    typedef logic [MAX_RESULTS-1:0][7:0] t_results;

    typedef struct packed {
        logic       in_str;
        logic       in_char;
        logic [7:0] prev;
        logic [7:0] prev2;
        logic [1:0] pos;
    } t_line;

    // starter byte k, bytes past the 32-bit register compare as zero
    function automatic logic [7:0] starter_byte(logic [31:0] sb, int k);
        logic [7:0] b;
        b = 8'h00;
        if (k < 4) begin
            b = sb[8*k +: 8];
        end
        return b;
    endfunction

endpackage

[rtl/core/line_comment_stripper.sv]
// line_comment_stripper: line comment removal with string and char literal tracking
// path: an accepted item is held in the input register until the result buffer is free
// throughput: one item per cycle while the receiver is ready and each item gives at most one
//   result; an item giving n results (up to four, newline flush included) holds the buffer
// reset: synchronous active-low i_rst_n clears line state, counts and config to defaults
module line_comment_stripper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // text in
    input  logic                          i_text_valid,
    output logic                          o_text_ready,
    input  logic [7:0]                    i_text_byte,
    // cleaned text out
    output logic                          o_kept_valid,
    input  logic                          i_kept_ready,
    output logic [7:0]                    o_kept_byte,
    output logic                          o_last_of_run,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [lcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data
);

    // config registers
    logic [2:0]                r_len;
    logic [31:0]               r_starter;
    logic [lcs_pkg::CNT_W-1:0] eff_len;

    // input register
    logic                      r_in_valid;
    logic [7:0]                r_in_byte;

    // line state and lookahead window
    lcs_pkg::t_line            r_line;
    lcs_pkg::t_window          r_win;
    logic [lcs_pkg::CNT_W-1:0] r_pend_cnt;
    logic                      r_discard;

    lcs_pkg::t_line            n_line;
    lcs_pkg::t_window          n_win;
    logic [lcs_pkg::CNT_W-1:0] n_pend_cnt;
    logic                      n_discard;
    lcs_pkg::t_results         res;
    logic [lcs_pkg::RES_W-1:0] res_cnt;

    logic                      buf_free;
    logic                      fire;

    // lengths past the window depth act as the full depth
    assign eff_len = (int'(r_len) > lcs_pkg::MAX_STARTER)
                     ? lcs_pkg::CNT_W'(lcs_pkg::MAX_STARTER) : lcs_pkg::CNT_W'(r_len);

    // the held item is processed once the result buffer can take its results
    assign fire         = r_in_valid && buf_free;
    assign o_text_ready = !r_in_valid || buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= lcs_pkg::RST_STARTER_LENGTH;
            r_starter <= lcs_pkg::RST_STARTER_BYTES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lcs_pkg::REG_STARTER_LENGTH: r_len     <= i_cfg_data[2:0];
                lcs_pkg::REG_STARTER_BYTES:  r_starter <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_text_ready) begin
            r_in_valid <= i_text_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text_valid && o_text_ready) begin
            r_in_byte <= i_text_byte;
        end
    end

    // per-line state advances once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line     <= '0;
            r_pend_cnt <= '0;
            r_discard  <= 1'b0;
        end else if (fire) begin
            r_line     <= n_line;
            r_pend_cnt <= n_pend_cnt;
            r_discard  <= n_discard;
        end
    end

    // held bytes are only read below the fill count, so no reset
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_win <= n_win;
        end
    end

    lcs_step u_step (
        .i_byte    (r_in_byte),
        .i_line    (r_line),
        .i_win     (r_win),
        .i_cnt     (r_pend_cnt),
        .i_discard (r_discard),
        .i_len     (eff_len),
        .i_starter (r_starter),
        .o_line    (n_line),
        .o_win     (n_win),
        .o_cnt     (n_pend_cnt),
        .o_discard (n_discard),
        .o_res     (res),
        .o_res_cnt (res_cnt)
    );

    lcs_out_buf u_out_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (fire),
        .i_res     (res),
        .i_res_cnt (res_cnt),
        .o_free    (buf_free),
        .o_valid   (o_kept_valid),
        .i_ready   (i_kept_ready),
        .o_byte    (o_kept_byte),
        .o_last    (o_last_of_run)
    );

    // window never holds MAX_STARTER bytes between items
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt <= lcs_pkg::CNT_W'(lcs_pkg::MAX_STARTER - 1))
        else $error("pending count beyond window");

    // a found comment leaves nothing held
    a_discard_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discard |-> (r_pend_cnt == '0))
        else $error("bytes held while discarding");

    // newline starts a clean line
    a_nl_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_in_byte == lcs_pkg::CH_NL)) |=>
            ((r_pend_cnt == '0) && !r_discard && (r_line == '0)))
        else $error("line state not cleared at newline");

    // newline always emits at least the newline itself
    a_nl_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_in_byte == lcs_pkg::CH_NL)) |=> o_kept_valid)
        else $error("newline produced no result");

    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line.pos <= 2'd2)
        else $error("line position past saturation");

endmodule

[rtl/core/lcs_step.sv]
module lcs_step (
    input  logic [7:0]                i_byte,
    input  lcs_pkg::t_line            i_line,
    input  lcs_pkg::t_window          i_win,
    input  logic [lcs_pkg::CNT_W-1:0] i_cnt,
    input  logic                      i_discard,
    input  logic [lcs_pkg::CNT_W-1:0] i_len,
    input  logic [31:0]               i_starter,
    output lcs_pkg::t_line            o_line,
    output lcs_pkg::t_window          o_win,
    output logic [lcs_pkg::CNT_W-1:0] o_cnt,
    output logic                      o_discard,
    output lcs_pkg::t_results         o_res,
    output logic [lcs_pkg::RES_W-1:0] o_res_cnt
);

    localparam int M  = lcs_pkg::MAX_STARTER;
    localparam int SW = lcs_pkg::CNT_W + 1;

    logic                       escaped;
    logic                       n_str;
    logic                       n_char;
    lcs_pkg::t_entry            entry;
    lcs_pkg::t_window           nw;
    logic [SW-1:0]              m;
    logic [SW-1:0]              len_w;
    logic [M-1:0]               cand;
    logic                       found;
    logic [SW-1:0]              first;
    logic [SW-1:0]              rel;
    logic [SW-1:0]              src;
    logic                       hit;

    always_comb begin
        escaped = (i_line.pos != 2'd0) && (i_line.prev == lcs_pkg::CH_BSLASH)
                  && !((i_line.pos >= 2'd2) && (i_line.prev2 == lcs_pkg::CH_BSLASH));
        n_str  = i_line.in_str;
        n_char = i_line.in_char;
        if ((i_byte == lcs_pkg::CH_DQUOTE) && !i_line.in_char) begin
            n_str = i_line.in_str ^ !escaped;
        end else if ((i_byte == lcs_pkg::CH_SQUOTE) && !i_line.in_str) begin
            n_char = i_line.in_char ^ !escaped;
        end
        entry.outside = !n_str && !n_char;
        entry.data    = i_byte;

        // push the new byte behind the held ones
        nw = i_win;
        for (int j = 0; j < M; j++) begin
            if (lcs_pkg::CNT_W'(j) == i_cnt) begin
                nw[j] = entry;
            end
        end
        m     = SW'(i_cnt) + SW'(1);
        len_w = SW'(i_len);

        // starter hit at each window position whose span is complete
        for (int p = 0; p < M; p++) begin
            hit = (len_w != '0) && ((SW'(p) + len_w) <= m) && nw[p].outside;
            for (int k = 0; k < M; k++) begin
                if (SW'(k) < len_w) begin
                    if (p + k < M) begin
                        hit = hit && (nw[lcs_pkg::IDX_W'(p + k)].data
                                      == lcs_pkg::starter_byte(i_starter, k));
                    end else begin
                        hit = 1'b0;
                    end
                end
            end
            cand[p] = hit;
        end

        found = 1'b0;
        first = '0;
        for (int p = M - 1; p >= 0; p--) begin
            if (cand[p]) begin
                found = 1'b1;
                first = SW'(p);
            end
        end

        // bytes released in front of a hit or of the undecided tail
        if (len_w == '0) begin
            rel = m;
        end else if (found) begin
            rel = first;
        end else if (m >= len_w) begin
            rel = m - len_w + SW'(1);
        end else begin
            rel = '0;
        end

        src       = '0;
        o_line    = i_line;
        o_win     = i_win;
        o_cnt     = i_cnt;
        o_discard = i_discard;
        o_res     = '0;
        o_res_cnt = '0;

        if (i_byte == lcs_pkg::CH_NL) begin
            // flush the held bytes, newline last, then start a fresh line
            for (int j = 0; j < M + 1; j++) begin
                if (SW'(j) < SW'(i_cnt)) begin
                    o_res[j] = i_win[lcs_pkg::IDX_W'(j)].data;
                end else begin
                    o_res[j] = lcs_pkg::CH_NL;
                end
            end
            o_res_cnt = lcs_pkg::RES_W'(i_cnt) + lcs_pkg::RES_W'(1);
            o_line    = '0;
            o_cnt     = '0;
            o_discard = 1'b0;
        end else if (!i_discard) begin
            o_line.in_str  = n_str;
            o_line.in_char = n_char;
            o_line.prev2   = i_line.prev;
            o_line.prev    = i_byte;
            if (i_line.pos < 2'd2) begin
                o_line.pos = i_line.pos + 2'd1;
            end
            for (int j = 0; j < M; j++) begin
                o_res[j] = nw[j].data;
            end
            o_res_cnt = lcs_pkg::RES_W'(rel);
            if (found) begin
                o_cnt     = '0;
                o_discard = 1'b1;
            end else begin
                o_cnt = lcs_pkg::CNT_W'(m - rel);
            end
            // slide the undecided bytes to the front
            for (int j = 0; j < M; j++) begin
                src      = SW'(j) + rel;
                o_win[j] = nw[j];
                if (src < SW'(M)) begin
                    o_win[j] = nw[lcs_pkg::IDX_W'(src)];
                end
            end
        end
    end

endmodule

[rtl/core/lcs_out_buf.sv]
module lcs_out_buf (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  lcs_pkg::t_results         i_res,
    input  logic [lcs_pkg::RES_W-1:0] i_res_cnt,
    output logic                      o_free,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [7:0]                o_byte,
    output logic                      o_last
);

    lcs_pkg::t_results         r_buf;
    logic [lcs_pkg::RES_W-1:0] r_rem;
    logic                      take;

    assign o_valid = (r_rem != '0);
    assign o_byte  = r_buf[0];
    assign o_last  = (r_rem == lcs_pkg::RES_W'(1));
    assign take    = o_valid && i_ready;
    // free when empty or when the last queued byte leaves this cycle
    assign o_free  = (r_rem == '0) || (o_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_load) begin
            r_rem <= i_res_cnt;
        end else if (take) begin
            r_rem <= r_rem - lcs_pkg::RES_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_res;
        end else if (take) begin
            for (int j = 0; j < lcs_pkg::MAX_RESULTS - 1; j++) begin
                r_buf[j] <= r_buf[j+1];
            end
        end
    end

endmodule

[tb/tb_top.sv]
module tb_top;

    import lcs_pkg::*;

    // expected item on the cleaned text side
    typedef struct packed {
        logic [7:0] kept;
        logic       last;
    } t_kept;

    // receiver ready patterns
    typedef enum int {RX_FREE, RX_COIN, RX_SLOW} t_rx_mode;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    // ------------------------------------------------------------------
    // scoreboard: tracks line state, predicts the cleaned text, checks it
    // ------------------------------------------------------------------
    class strip_scoreboard;
        // register copies
        logic [2:0]  starter_len;
        logic [31:0] starter_word;
        // line state
        bit          in_str;
        bit          in_chr;
        logic [7:0]  prev1;
        logic [7:0]  prev2;
        logic [1:0]  pos;
        t_entry      held [MAX_STARTER];
        int          held_cnt;
        bit          dropping;
        // expected cleaned text, oldest first
        t_kept       kept_q[$];
        // statistics
        int          failures;
        int          items_seen;
        int          kept_seen;
        int          comments;

        function new();
            starter_len  = RST_STARTER_LENGTH;
            starter_word = RST_STARTER_BYTES;
            failures     = 0;
            items_seen   = 0;
            kept_seen    = 0;
            comments     = 0;
            clear_line();
        endfunction

        function void clear_line();
            in_str   = 0;
            in_chr   = 0;
            prev1    = '0;
            prev2    = '0;
            pos      = '0;
            held_cnt = 0;
            dropping = 0;
            foreach (held[k]) held[k] = '0;
        endfunction

        function void queue_kept(input logic [7:0] b);
            t_kept e;
            e.kept = b;
            e.last = 1'b0;
            kept_q.push_back(e);
        endfunction

        function int pending();
            return kept_q.size();
        endfunction

        function void note_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
            if (idx == REG_STARTER_LENGTH) begin
                starter_len = val[2:0];
            end else begin
                starter_word = val;
            end
        endfunction

        // predict the kept items that one accepted text item releases
        function void note_text(input logic [7:0] c);
            int eff;
            int first;
            int k;
            bit esc;
            bit hit;
            eff   = (starter_len > MAX_STARTER) ? MAX_STARTER : int'(starter_len);
            first = kept_q.size();
            items_seen++;
            // newline flushes the held bytes, then itself
            if (c == CH_NL) begin
                for (k = 0; k < held_cnt; k++) queue_kept(held[k].data);
                queue_kept(CH_NL);
                kept_q[kept_q.size()-1].last = 1'b1;
                clear_line();
                return;
            end
            if (dropping) return;
            // a single backslash escapes a quote, a double one does not
            esc = (pos != 0) && (prev1 == CH_BSLASH) && !(pos >= 2 && prev2 == CH_BSLASH);
            if (c == CH_DQUOTE && !in_chr) begin
                if (!esc) in_str = !in_str;
            end else if (c == CH_SQUOTE && !in_str) begin
                if (!esc) in_chr = !in_chr;
            end
            prev2 = prev1;
            prev1 = c;
            if (pos < 2) pos++;
            if (held_cnt < MAX_STARTER) begin
                held[held_cnt].outside = !in_str && !in_chr;
                held[held_cnt].data    = c;
                held_cnt++;
            end
            // decide every held byte that has a full window behind it
            while (held_cnt > 0 && (eff == 0 || held_cnt >= eff)) begin
                hit = (eff > 0) && held[0].outside;
                for (k = 0; k < eff; k++) begin
                    if (held[k].data != starter_word[8*k +: 8]) hit = 0;
                end
                if (hit) begin
                    held_cnt = 0;
                    dropping = 1;
                    comments++;
                    break;
                end
                queue_kept(held[0].data);
                for (k = 1; k < held_cnt; k++) held[k-1] = held[k];
                held_cnt--;
            end
            if (kept_q.size() > first) kept_q[kept_q.size()-1].last = 1'b1;
        endfunction

        function void check_kept(input logic [7:0] b, input logic last);
            t_kept w;
            kept_seen++;
            if (kept_q.size() == 0) begin
                if (failures < 10)
                    $display("%0t: unexpected kept item byte=%02h last=%b", $time, b, last);
                failures++;
                return;
            end
            w = kept_q.pop_front();
            if (w.kept !== b || w.last !== last) begin
                if (failures < 10)
                    $display("%0t: kept item mismatch: exp byte=%02h last=%b, got byte=%02h last=%b",
                             $time, w.kept, w.last, b, last);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block signals
    // ------------------------------------------------------------------
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_text_valid = 1'b0;
    logic                 o_text_ready;
    logic [7:0]           i_text_byte  = '0;
    logic                 o_kept_valid;
    logic                 i_kept_ready = 1'b0;
    logic [7:0]           o_kept_byte;
    logic                 o_last_of_run;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx    = '0;
    logic [31:0]          i_cfg_data   = '0;

    strip_scoreboard sb = new();

    // sender burst bookkeeping
    int burst_left = 0;
    int settings   = 0;

    // receiver pattern bookkeeping
    t_rx_mode rx_mode = RX_FREE;
    int       rx_left = 0;
    int       rx_tick = 0;

    always #5 i_clk = ~i_clk;

    line_comment_stripper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_text_valid  (i_text_valid),
        .o_text_ready  (o_text_ready),
        .i_text_byte   (i_text_byte),
        .o_kept_valid  (o_kept_valid),
        .i_kept_ready  (i_kept_ready),
        .o_kept_byte   (o_kept_byte),
        .o_last_of_run (o_last_of_run),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offer one text item and hold it until accepted; between bursts the
    // valid drops for a random gap, inside a burst the next item follows
    // at once, so the caller must offer the next item or drain right away
    task automatic send_byte(input logic [7:0] b);
        int gap;
        i_text_valid <= 1'b1;
        i_text_byte  <= b;
        @(posedge i_clk);
        while (!o_text_ready) @(posedge i_clk);
        sb.note_text(b);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                      : $urandom_range(0, 8);
            gap = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 8 : 2);
            i_text_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // stop sending and wait until every predicted item came out, plus the
    // pipeline depth so that items with no output have left the block too
    task automatic drain();
        i_text_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // both registers, written only with the block idle
    task automatic set_starter(input logic [2:0] len, input logic [31:0] word);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_STARTER_LENGTH;
        i_cfg_data <= {29'd0, len};
        @(posedge i_clk);
        sb.note_cfg(REG_STARTER_LENGTH, {29'd0, len});
        i_cfg_idx  <= REG_STARTER_BYTES;
        i_cfg_data <= word;
        @(posedge i_clk);
        sb.note_cfg(REG_STARTER_BYTES, word);
        i_cfg_we   <= 1'b0;
        settings++;
    endtask

    // one line of random text, biased toward quotes, escapes and the
    // current starter so that literals and comments show up often
    task automatic send_line();
        int n;
        int i;
        int k;
        int r;
        int eff;
        eff = (sb.starter_len > MAX_STARTER) ? MAX_STARTER : int'(sb.starter_len);
        n   = $urandom_range(0, 12);
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_byte(CH_DQUOTE);
            end else if (r < 20) begin
                send_byte(CH_SQUOTE);
            end else if (r < 28) begin
                send_byte(CH_BSLASH);
            end else if (r < 40) begin
                // whole starter
                for (k = 0; k < eff; k++) send_byte(sb.starter_word[8*k +: 8]);
            end else if (r < 45) begin
                // broken starter, first byte only
                send_byte(sb.starter_word[7:0]);
            end else if (r < 60) begin
                // noise, any byte value, newline included
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(8'($urandom_range(97, 122)));
            end
        end
        // most lines end properly, some run on into the next setting
        if ($urandom_range(0, 9) != 0) send_byte(CH_NL);
    endtask

    // ------------------------------------------------------------------
    // receiver side: check every accepted item, stall on its own pattern
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_kept_ready <= 1'b0;
        end else begin
            if (o_kept_valid && i_kept_ready) begin
                sb.check_kept(o_kept_byte, o_last_of_run);
            end
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
                rx_left = $urandom_range(10, 60);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_FREE: begin
                    i_kept_ready <= 1'b1;
                end
                RX_COIN: begin
                    i_kept_ready <= ($urandom_range(0, 1) == 1);
                end
                default: begin
                    i_kept_ready <= (rx_tick % 5 == 0);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        logic [2:0]  phase_len [8];
        logic [31:0] word;
        int          p;
        int          k;
        int          target;
        phase_len = '{3'd2, 3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd5, 3'd6};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, default starter "//"
        // quote at line start opens a string, so the starter inside is text
        send_text("\"//\"\n");
        // single backslash escapes the quote, the starter then opens a comment
        send_text("\\\"//\n");
        // double backslash does not escape, char literal shields the starter
        send_text("\\\\'//\n");

        // hold three bytes under a long starter holding a newline, then
        // shorten it mid-line: the next byte releases all four at once
        set_starter(3'd4, {CH_NL, CH_SLASH, CH_SLASH, CH_SLASH});
        send_text("///");
        set_starter(3'd1, 32'h0000_0078);
        send_byte(8'h79);
        send_byte(8'h00);
        send_byte(8'hFF);
        // comment found: the rest of the line gives nothing but the newline
        send_byte(8'h78);
        send_byte(8'h41);
        send_byte(CH_NL);

        // stripping disabled, every byte passes at once
        set_starter(3'd0, {16'd0, CH_SLASH, CH_SLASH});
        send_text("a//\n");

        // random phases over a spread of starter settings
        for (p = 0; p < 8; p++) begin
            case (p)
                2: word = 32'hFFFF_FFFF;
                5: word = 32'h0000_0000;
                default: begin
                    for (k = 0; k < 4; k++) begin
                        case ($urandom_range(0, 7))
                            0, 1, 2: word[8*k +: 8] = CH_SLASH;
                            3:       word[8*k +: 8] = CH_HASH;
                            4:       word[8*k +: 8] = CH_STAR;
                            5:       word[8*k +: 8] = CH_NL;
                            6:       word[8*k +: 8] = CH_DQUOTE;
                            default: word[8*k +: 8] = 8'($urandom_range(0, 255));
                        endcase
                    end
                end
            endcase
            // a starter that holds a newline can never match
            if (p == 6) word[15:8] = CH_NL;
            set_starter(phase_len[p], word);
            target = sb.items_seen + 25;
            while (sb.items_seen < target) send_line();
        end

        // let everything come out, then the pipeline settle
        drain();

        $display("run covered %0d text items and %0d kept items over %0d starter settings",
                 sb.items_seen, sb.kept_seen, settings);
        $display("%0d comments stripped, %0d failures", sb.comments, sb.failures);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("line_comment_stripper verification clean");
        end else begin
            $display("line_comment_stripper verification failed");
        end
        $finish;
    end

    // watchdog for a hung handshake
    initial begin
        #3000000;
        $display("line_comment_stripper verification failed");
        $finish;
    end

endmodule
